>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the path length checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> rtl/core/ppl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_pkg
// Widths, constants and types shared by the polyline path length blocks.
// ----------------------------------------------------------------------------
package ppl_pkg;

	// waypoint format
	localparam int MAX_JOINTS = 6;
	localparam int POS_W      = 32;
	localparam int JC_W       = 3;
	localparam logic [JC_W-1:0] JC_RESET = 3'd6;

	// arithmetic widths: exact difference, square, sum and root
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W   = 2 * DIFF_W - 1;
	localparam int PAIRS  = (MAX_JOINTS + 1) / 2;
	localparam int PAIR_W = SQ_W + 1;
	localparam int SUM_W  = SQ_W + $clog2(MAX_JOINTS);
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;

	// square root unit: partial remainder and iteration counter
	localparam int SQRT_REM_W = ROOT_W + 2;
	localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

	// accumulator
	localparam int LEN_W = 48;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// waypoint counter saturates at two
	localparam int CNT_W = 2;
	localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [SQ_W-1:0]         sq_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_PAIR,
		ST_SUM,
		ST_START,
		ST_ROOT,
		ST_ACCUM
	} state_t;

	// sequencer controls
	typedef struct packed {
		logic in_ready;
		logic load;
		logic root_start;
		logic accum;
	} ctrl_t;

endpackage

>>> rtl/core/ppl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_lane
// One joint lane: keeps the previous position, forms the exact step
// magnitude and squares it.
// ----------------------------------------------------------------------------
module ppl_lane (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           lane_on,
	input  ppl_pkg::pos_t  pos,
	output ppl_pkg::sq_t   sq
);

	ppl_pkg::pos_t                       prev_q;
	logic signed [ppl_pkg::DIFF_W-1:0]   diff;
	logic [ppl_pkg::DIFF_W-1:0]          mag;
	logic [ppl_pkg::DIFF_W-1:0]          mag_s1;
	logic [2*ppl_pkg::DIFF_W-1:0]        prod;
	ppl_pkg::sq_t                        sq_s2;

	// exact signed step and its magnitude
	assign diff = ppl_pkg::DIFF_W'(pos) - ppl_pkg::DIFF_W'(prev_q);
	assign mag  = diff[ppl_pkg::DIFF_W-1] ? ppl_pkg::DIFF_W'(-diff) : ppl_pkg::DIFF_W'(diff);

	// previous waypoint, replaced by every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (load) begin
			prev_q <= pos;
		end
	end

	// stage 1: magnitude, unused lanes contribute zero
	always_ff @(posedge clk) begin
		if (load) begin
			mag_s1 <= lane_on ? mag : '0;
		end
	end

	// stage 2: square
	assign prod = mag_s1 * mag_s1;

	always_ff @(posedge clk) begin
		sq_s2 <= prod[ppl_pkg::SQ_W-1:0];
	end

	assign sq = sq_s2;

endmodule

>>> rtl/core/ppl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_merge
// Two-level registered adder tree that merges the lane squares into the
// squared step length.
// ----------------------------------------------------------------------------
module ppl_merge (
	input  logic                        clk,
	input  ppl_pkg::sq_t                sq [ppl_pkg::MAX_JOINTS],
	output logic [ppl_pkg::SUM_W-1:0]   sum
);

	logic [ppl_pkg::PAIR_W-1:0] pair_s3 [ppl_pkg::PAIRS];
	logic [ppl_pkg::SUM_W-1:0]  total;
	logic [ppl_pkg::SUM_W-1:0]  sum_s4;

	// level 1: pairwise sums, an odd lane passes alone
	for (genvar p = 0; p < ppl_pkg::PAIRS; p++) begin : g_pair
		if (2 * p + 1 < ppl_pkg::MAX_JOINTS) begin : g_two
			always_ff @(posedge clk) begin
				pair_s3[p] <= ppl_pkg::PAIR_W'(sq[2*p]) + ppl_pkg::PAIR_W'(sq[2*p+1]);
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				pair_s3[p] <= ppl_pkg::PAIR_W'(sq[2*p]);
			end
		end
	end

	// level 2: sum of the pairs
	always_comb begin
		total = '0;
		for (int p = 0; p < ppl_pkg::PAIRS; p++) begin
			total = total + ppl_pkg::SUM_W'(pair_s3[p]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= total;
	end

	assign sum = sum_s4;

endmodule

>>> rtl/core/ppl_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_sqrt
// Restoring digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ppl_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ppl_pkg::SUM_W-1:0]   radicand,
	output logic                        busy,
	output logic [ppl_pkg::ROOT_W-1:0]  root
);

	logic [ppl_pkg::RAD_W-1:0]       rad_q;
	logic [ppl_pkg::SQRT_REM_W-1:0]  rem_q;
	logic [ppl_pkg::ROOT_W-1:0]      root_q;
	logic [ppl_pkg::SQRT_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic [ppl_pkg::SQRT_REM_W+1:0]  rem_sh;
	logic [ppl_pkg::SQRT_REM_W+1:0]  trial;
	logic                            fits;

	// bring down the next bit pair and try root*4+1
	assign rem_sh = {rem_q, rad_q[ppl_pkg::RAD_W-1 -: 2]};
	assign trial  = (ppl_pkg::SQRT_REM_W + 2)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ppl_pkg::SQRT_CNT_W'(ppl_pkg::ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ppl_pkg::SQRT_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= ppl_pkg::RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[ppl_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? ppl_pkg::SQRT_REM_W'(rem_sh - trial)
				: ppl_pkg::SQRT_REM_W'(rem_sh);
			root_q <= {root_q[ppl_pkg::ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

>>> rtl/core/polyline_path_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_path_length_unit
// Running Euclidean arc length of a joint-space polyline.
// ----------------------------------------------------------------------------
// Takes one waypoint word at a time: up to six signed Q15.16 joint positions
// plus segment_start and path_end flags. Each lane squares its exact step and
// a registered adder tree sums them; the floor square root of that sum is
// added to a saturating unsigned Q32.16 length. A word that adds a step passes
// through the accept, three more pipeline stages, a root load, the iterative
// square root (one result bit per cycle, 34 result bits) and an accumulate
// step, and the block takes no new word until it is through. A word that adds
// no step (first of a path or a segment start) goes from the accept straight
// to the accumulate step. On path_end one result word leaves through an output
// register with the total and a status of 1 when the path held fewer than two
// waypoints; the next word is taken while that result waits, but a second
// result waits until the first is taken.
// joint_count may be written only while the block is idle.
// ----------------------------------------------------------------------------
module polyline_path_length_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppl_pkg::JC_W-1:0]      joint_count,
	// waypoint words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ppl_pkg::pos_t                 joint_0,
	input  ppl_pkg::pos_t                 joint_1,
	input  ppl_pkg::pos_t                 joint_2,
	input  ppl_pkg::pos_t                 joint_3,
	input  ppl_pkg::pos_t                 joint_4,
	input  ppl_pkg::pos_t                 joint_5,
	input  logic                          segment_start,
	input  logic                          path_end,
	// result words
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ppl_pkg::LEN_W-1:0]     total_length,
	output logic                          status
);

	ppl_pkg::state_t              state_q, state_d;
	ppl_pkg::ctrl_t               ctrl;
	logic [ppl_pkg::JC_W-1:0]     jc_q;
	ppl_pkg::pos_t                pos [ppl_pkg::MAX_JOINTS];
	ppl_pkg::sq_t                 sq  [ppl_pkg::MAX_JOINTS];
	logic [ppl_pkg::SUM_W-1:0]    sum;
	logic                         root_busy;
	logic [ppl_pkg::ROOT_W-1:0]   root;
	logic                         accept;
	logic                         step_q;
	logic                         last_q;
	logic                         have_prev_q;
	logic [ppl_pkg::CNT_W-1:0]    count_q;
	logic [ppl_pkg::CNT_W-1:0]    count_inc;
	logic [ppl_pkg::LEN_W-1:0]    length_q;
	logic [ppl_pkg::LEN_W:0]      len_ext;
	logic [ppl_pkg::LEN_W-1:0]    len_new;
	logic                         out_free;
	logic                         commit;
	logic                         out_valid_q;
	logic [ppl_pkg::LEN_W-1:0]    total_length_q;
	logic                         status_q;

	// configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jc_q <= ppl_pkg::JC_RESET;
		end else if (cfg_valid) begin
			jc_q <= joint_count;
		end
	end

	assign pos[0] = joint_0;
	assign pos[1] = joint_1;
	assign pos[2] = joint_2;
	assign pos[3] = joint_3;
	assign pos[4] = joint_4;
	assign pos[5] = joint_5;

	assign accept = in_valid && ctrl.in_ready;

	// lanes
	for (genvar i = 0; i < ppl_pkg::MAX_JOINTS; i++) begin : g_lane
		ppl_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (ctrl.load),
			.lane_on (ppl_pkg::JC_W'(i) < jc_q),
			.pos     (pos[i]),
			.sq      (sq[i])
		);
	end

	ppl_merge u_merge (
		.clk (clk),
		.sq  (sq),
		.sum (sum)
	);

	ppl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.root_start),
		.radicand (sum),
		.busy     (root_busy),
		.root     (root)
	);

	// accumulate with saturation
	assign len_ext   = {1'b0, length_q}
		+ (ppl_pkg::LEN_W + 1)'(step_q ? root : '0);
	assign len_new   = (len_ext >= {1'b0, ppl_pkg::LEN_MAX})
		? ppl_pkg::LEN_MAX : len_ext[ppl_pkg::LEN_W-1:0];
	assign count_inc = (count_q == ppl_pkg::CNT_SAT) ? count_q : count_q + 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign commit    = ctrl.accum && (!last_q || out_free);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppl_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (have_prev_q && !segment_start)
						? ppl_pkg::ST_SQUARE : ppl_pkg::ST_ACCUM;
				end
			end
			ppl_pkg::ST_SQUARE: state_d = ppl_pkg::ST_PAIR;
			ppl_pkg::ST_PAIR:   state_d = ppl_pkg::ST_SUM;
			ppl_pkg::ST_SUM:    state_d = ppl_pkg::ST_START;
			ppl_pkg::ST_START:  state_d = ppl_pkg::ST_ROOT;
			ppl_pkg::ST_ROOT: begin
				if (!root_busy) begin
					state_d = ppl_pkg::ST_ACCUM;
				end
			end
			ppl_pkg::ST_ACCUM: begin
				if (commit) begin
					state_d = ppl_pkg::ST_IDLE;
				end
			end
			default: state_d = ppl_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ppl_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load     = in_valid;
			end
			ppl_pkg::ST_START: ctrl.root_start = 1'b1;
			ppl_pkg::ST_ACCUM: ctrl.accum      = 1'b1;
			default:           ctrl            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-word flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			last_q <= 1'b0;
		end else if (accept) begin
			step_q <= have_prev_q && !segment_start;
			last_q <= path_end;
		end
	end

	// path state, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			count_q     <= '0;
			length_q    <= '0;
		end else if (commit) begin
			if (last_q) begin
				have_prev_q <= 1'b0;
				count_q     <= '0;
				length_q    <= '0;
			end else begin
				have_prev_q <= 1'b1;
				count_q     <= count_inc;
				length_q    <= len_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && last_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && last_q) begin
			total_length_q <= len_new;
			status_q       <= (count_inc < ppl_pkg::CNT_SAT)
				? ppl_pkg::STATUS_SHORT : ppl_pkg::STATUS_OK;
		end
	end

	assign in_ready     = ctrl.in_ready;
	assign out_valid    = out_valid_q;
	assign total_length = total_length_q;
	assign status       = status_q;

endmodule

>>> rtl/core/ppl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_checker
// Port-level checks for the path length unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ppl_pkg::LEN_W-1:0]   total_length,
	input logic                        status
);

	// a stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(total_length) && $stable(status))

	// a short path never carries length
	`ASSERT_SAME(a_short_zero, clk, arst_n, out_valid && status == ppl_pkg::STATUS_SHORT,
		total_length == '0)

	// one word at a time: busy right after an accept
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

	// configuration is never back-pressured
	`ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg_valid || !cfg_valid, cfg_ready)

endmodule

bind polyline_path_length_unit ppl_checker u_ppl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.total_length (total_length),
	.status       (status)
);
